[rtl/bac_pkg.sv]
package bac_pkg;

   localparam int WORD_BITS   = 16;
   localparam int ADDR_BITS   = 4;
   localparam int MEM_WORDS   = 16;
   localparam int PC_BITS     = 8;
   localparam int ROP_BITS    = 12;
   localparam int CMD_BITS    = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CMD_BITS-1:0] {
      OP_AND = 3'd0,
      OP_ADD = 3'd1,
      OP_LDA = 3'd2,
      OP_STA = 3'd3,
      OP_BUN = 3'd4,
      OP_BSA = 3'd5,
      OP_ISZ = 3'd6,
      OP_REG = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      ROP_NONE,
      ROP_CLA,
      ROP_CMA,
      ROP_INC,
      ROP_SPA,
      ROP_SNA,
      ROP_SZA
   } rop_type;

   localparam logic [ROP_BITS-1:0] CODE_CLA = 12'h800;
   localparam logic [ROP_BITS-1:0] CODE_CMA = 12'h200;
   localparam logic [ROP_BITS-1:0] CODE_INC = 12'h020;
   localparam logic [ROP_BITS-1:0] CODE_SPA = 12'h010;
   localparam logic [ROP_BITS-1:0] CODE_SNA = 12'h008;
   localparam logic [ROP_BITS-1:0] CODE_SZA = 12'h004;

   typedef struct packed {
      opcode_type             opcode;
      logic                   indirect;
      logic [ADDR_BITS-1:0]   address;
      rop_type                rop;
   } inst_type;

   typedef enum logic [1:0] {
      EX_IDLE,
      EX_PTR,
      EX_EXEC
   } ex_state_type;

   // power-up image of the data memory
   function automatic logic [WORD_BITS-1:0] mem_reset_word(input logic [ADDR_BITS-1:0] a);
      logic [WORD_BITS-1:0] w;
      case (a)
         4'd0:    w = 16'd2;
         4'd1:    w = 16'd4;
         4'd2:    w = 16'd7;
         4'd3:    w = 16'd8;
         4'd4:    w = 16'd9;
         4'd5:    w = 16'd1;
         4'd6:    w = 16'd3;
         4'd7:    w = 16'd6;
         4'd8:    w = 16'd5;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

[rtl/bac_front.sv]
module bac_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bac_pkg::CMD_BITS-1:0]  req_command,
   input  logic                          req_indirect,
   input  logic [bac_pkg::ADDR_BITS-1:0] req_address,
   input  logic [bac_pkg::ROP_BITS-1:0]  req_register_op,
   output logic                          q_valid,
   output bac_pkg::inst_type             q_head,
   input  logic                          q_pop
);
   import bac_pkg::*;

   inst_type              decoded;
   inst_type              q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff;
   logic [QPTR_BITS-1:0]  rd_ptr_ff;
   logic [QCNT_BITS-1:0]  count_ff;
   logic [QCNT_BITS-1:0]  count_in;
   logic                  push;

   // classify the instruction word
   always_comb begin
      decoded.opcode   = opcode_type'(req_command);
      decoded.indirect = req_indirect && (opcode_type'(req_command) != OP_REG);
      decoded.address  = req_address;
      case (req_register_op)
         CODE_CLA: decoded.rop = ROP_CLA;
         CODE_CMA: decoded.rop = ROP_CMA;
         CODE_INC: decoded.rop = ROP_INC;
         CODE_SPA: decoded.rop = ROP_SPA;
         CODE_SNA: decoded.rop = ROP_SNA;
         CODE_SZA: decoded.rop = ROP_SZA;
         default:  decoded.rop = ROP_NONE;
      endcase
   end

   assign req_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_head    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= decoded;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (count_ff != '0))
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");
`endif

endmodule

[rtl/bac_back.sv]
module bac_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  bac_pkg::inst_type                    q_head,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bac_pkg::WORD_BITS-1:0] rsp_acc_value,
   output logic [bac_pkg::PC_BITS-1:0]          rsp_next_pc,
   output logic                                 rsp_store_enable,
   output logic [bac_pkg::ADDR_BITS-1:0]        rsp_store_address,
   output logic signed [bac_pkg::WORD_BITS-1:0] rsp_store_value,
   output logic                                 rsp_skip_taken
);
   import bac_pkg::*;

   ex_state_type          state_ff;
   ex_state_type          state_in;
   inst_type              cur_ff;
   logic [ADDR_BITS-1:0]  ea_ff;

   logic [WORD_BITS-1:0]  mem [MEM_WORDS];
   logic [MEM_WORDS-1:0]  written_ff;
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  rd_en;
   logic [ADDR_BITS-1:0]  rd_addr;

   logic [WORD_BITS-1:0]  acc_ff;
   logic [WORD_BITS-1:0]  acc_in;
   logic [PC_BITS-1:0]    pc_ff;
   logic [PC_BITS-1:0]    pc_in;
   logic [PC_BITS-1:0]    pc_inc;
   logic [PC_BITS-1:0]    ea_pc;
   logic [WORD_BITS-1:0]  isz_word;

   logic                  out_free;
   logic                  fire;
   logic                  st;
   logic [WORD_BITS-1:0]  st_val;
   logic                  skip;

   logic                  rsp_valid_ff;
   logic [WORD_BITS-1:0]  rsp_acc_ff;
   logic [PC_BITS-1:0]    rsp_pc_ff;
   logic                  rsp_st_ff;
   logic [ADDR_BITS-1:0]  rsp_addr_ff;
   logic [WORD_BITS-1:0]  rsp_val_ff;
   logic                  rsp_skip_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EX_IDLE: begin
            if (q_valid) begin
               state_in = q_head.indirect ? EX_PTR : EX_EXEC;
            end
         end
         EX_PTR: begin
            state_in = EX_EXEC;
         end
         EX_EXEC: begin
            if (out_free) begin
               state_in = EX_IDLE;
            end
         end
         default: state_in = EX_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      q_pop   = 1'b0;
      rd_en   = 1'b0;
      rd_addr = q_head.address;
      fire    = 1'b0;
      case (state_ff)
         EX_IDLE: begin
            q_pop = q_valid;
            rd_en = q_valid;
         end
         EX_PTR: begin
            rd_en   = 1'b1;
            rd_addr = rd_data_ff[ADDR_BITS-1:0];
         end
         EX_EXEC: begin
            fire = out_free;
         end
         default: begin
            fire = 1'b0;
         end
      endcase
   end

   assign pc_inc   = pc_ff + 1'b1;
   assign ea_pc    = {{(PC_BITS-ADDR_BITS){1'b0}}, ea_ff};
   assign isz_word = rd_data_ff + 1'b1;

   // execute; rd_data_ff holds the operand in EX_EXEC
   always_comb begin
      acc_in = acc_ff;
      pc_in  = pc_inc;
      st     = 1'b0;
      st_val = '0;
      skip   = 1'b0;
      case (cur_ff.opcode)
         OP_AND: acc_in = acc_ff & rd_data_ff;
         OP_ADD: acc_in = acc_ff + rd_data_ff;
         OP_LDA: acc_in = rd_data_ff;
         OP_STA: begin
            st     = 1'b1;
            st_val = acc_ff;
         end
         OP_BUN: pc_in = ea_pc;
         OP_BSA: begin
            st     = 1'b1;
            st_val = {{(WORD_BITS-PC_BITS){1'b0}}, pc_inc};
            pc_in  = ea_pc + 1'b1;
         end
         OP_ISZ: begin
            st     = 1'b1;
            st_val = isz_word;
            skip   = (isz_word == '0);
         end
         OP_REG: begin
            case (cur_ff.rop)
               ROP_CLA: acc_in = '0;
               ROP_CMA: acc_in = ~acc_ff;
               ROP_INC: acc_in = acc_ff + 1'b1;
               ROP_SPA: skip = (acc_ff != '0) && !acc_ff[WORD_BITS-1];
               ROP_SNA: skip = acc_ff[WORD_BITS-1];
               ROP_SZA: skip = (acc_ff == '0);
               default: acc_in = acc_ff;
            endcase
         end
         default: acc_in = acc_ff;
      endcase
      if (skip) begin
         pc_in = pc_inc + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EX_IDLE;
         acc_ff       <= '0;
         pc_ff        <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            acc_ff       <= acc_in;
            pc_ff        <= pc_in;
            rsp_valid_ff <= 1'b1;
            if (st) begin
               written_ff[ea_ff] <= 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // data memory: entries not yet written read as the power-up image
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= written_ff[rd_addr] ? mem[rd_addr] : mem_reset_word(rd_addr);
      end
      if (fire && st) begin
         mem[ea_ff] <= st_val;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
         ea_ff  <= q_head.address;
      end else if (state_ff == EX_PTR) begin
         ea_ff <= rd_data_ff[ADDR_BITS-1:0];
      end
      if (fire) begin
         rsp_acc_ff  <= acc_in;
         rsp_pc_ff   <= pc_in;
         rsp_st_ff   <= st;
         rsp_addr_ff <= st ? ea_ff : '0;
         rsp_val_ff  <= st_val;
         rsp_skip_ff <= skip;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_acc_value     = $signed(rsp_acc_ff);
   assign rsp_next_pc       = rsp_pc_ff;
   assign rsp_store_enable  = rsp_st_ff;
   assign rsp_store_address = rsp_addr_ff;
   assign rsp_store_value   = $signed(rsp_val_ff);
   assign rsp_skip_taken    = rsp_skip_ff;

`ifndef SYNTHESIS
   a_ptr_from_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EX_PTR) |-> ($past(state_ff) == EX_IDLE))
      else $error("pointer fetch not entered from idle");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("executed transaction produced no response");

   a_store_marks: assert property (@(posedge clock) disable iff (reset)
      (fire && st) |=> written_ff[$past(ea_ff)])
      else $error("stored word not marked as written");
`endif

endmodule

[rtl/basic_accumulator_cpu_execute.sv]
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | command, indirect, address, register_op
// rsp     | out       | rsp_valid / rsp_ready | acc_value, next_pc, store_*, skip_taken
//
// In the execute sequencer each data-memory access is a registered read, and an
// indirect instruction adds the pointer read in EX_PTR.
// Reset clears AC and PC and restores the memory power-up image.
// A 2-entry queue lets req keep flowing while rsp is stalled until the queue fills; the execute side
// holds a finished transaction in the response register until it is taken.
module basic_accumulator_cpu_execute (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bac_pkg::CMD_BITS-1:0]         req_command,
   input  logic                                 req_indirect,
   input  logic [bac_pkg::ADDR_BITS-1:0]        req_address,
   input  logic [bac_pkg::ROP_BITS-1:0]         req_register_op,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bac_pkg::WORD_BITS-1:0] rsp_acc_value,
   output logic [bac_pkg::PC_BITS-1:0]          rsp_next_pc,
   output logic                                 rsp_store_enable,
   output logic [bac_pkg::ADDR_BITS-1:0]        rsp_store_address,
   output logic signed [bac_pkg::WORD_BITS-1:0] rsp_store_value,
   output logic                                 rsp_skip_taken
);
   import bac_pkg::*;

   logic      q_valid;
   inst_type  q_head;
   logic      q_pop;

   bac_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_indirect    (req_indirect),
      .req_address     (req_address),
      .req_register_op (req_register_op),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (q_pop)
   );

   bac_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_acc_value     (rsp_acc_value),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_store_enable  (rsp_store_enable),
      .rsp_store_address (rsp_store_address),
      .rsp_store_value   (rsp_store_value),
      .rsp_skip_taken    (rsp_skip_taken)
   );

endmodule
